### rtl/core/cirm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cirm_pkg;
  localparam int unsigned MaxIds    = 32;
  localparam int unsigned IdxW      = $clog2(MaxIds);
  localparam int unsigned CntW      = $clog2(MaxIds + 1);
  localparam int unsigned TotW      = 21;
  localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};
  localparam logic [31:0] WindowRst = 32'd1000000;
  localparam logic [15:0] TallyMax  = 16'hFFFF;
  localparam logic [3:0]  DataMax   = 4'd8;

  localparam logic [1:0] CmdRecord = 2'd0;
  localparam logic [1:0] CmdTime   = 2'd1;
  localparam logic [1:0] CmdSnap   = 2'd2;
  localparam logic [1:0] CmdClear  = 2'd3;

  localparam logic [2:0] StStored  = 3'd0;
  localparam logic [2:0] StDropped = 3'd1;
  localparam logic [2:0] StWinStart= 3'd2;
  localparam logic [2:0] StWinOpen = 3'd3;
  localparam logic [2:0] StLatched = 3'd4;
  localparam logic [2:0] StEntry   = 3'd5;
  localparam logic [2:0] StEmpty   = 3'd6;
  localparam logic [2:0] StCleared = 3'd7;

  // ident = {extended, can_id}; compares as the sort key directly
  typedef struct packed {
    logic [29:0] ident;
    logic [63:0] data;
    logic [3:0]  len;
    logic [31:0] total;
    logic [31:0] stamp;
    logic [15:0] tally;
    logic [15:0] rate;
  } entry_t;
  localparam int unsigned EntryW = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic            capture;   // latch input item
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            scan_cmp;  // compare read entry with item ident
    logic            wr_rec;    // write record update to rd entry
    logic            wr_new;    // write fresh entry at used
    logic            wr_latch;  // rate latch write
    logic            sum_clr;
    logic            sum_add;
    logic            win_set;   // start/restart window
    logic            clear;     // empty table
    logic            sel_init;  // start selection pass
    logic            sel_cmp;   // compare read entry for selection
    logic            sel_take;  // record chosen as emitted key
    logic            out_load;
    logic            out_entry;  // load entry from selected read
    logic [2:0]      out_status;
    logic            out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0]      command;
    logic [CntW-1:0] used;
    logic [CntW-1:0] snap_cnt;
    logic            match;
    logic            win_started;
    logic            win_elapsed;
    logic            out_busy;
    logic [IdxW-1:0] sel_idx;
  } stat_t;
endpackage
`default_nettype wire

### rtl/core/cirm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cirm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/cirm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module cirm_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic [1:0]         command_i,
  input  wire logic [28:0]        can_id_i,
  input  wire logic               extended_i,
  input  wire logic [63:0]        payload_i,
  input  wire logic [3:0]         dlc_i,
  input  wire logic [31:0]        time_us_i,
  input  wire logic [5:0]         snapshot_limit_i,
  input  wire cirm_pkg::cmd_t     cmd_i,
  output cirm_pkg::stat_t         stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              status_o,
  output logic [28:0]             entry_can_id_o,
  output logic                    entry_extended_o,
  output logic [3:0]              entry_dlc_o,
  output logic [63:0]             entry_payload_o,
  output logic [31:0]             entry_frame_count_o,
  output logic [31:0]             entry_last_time_us_o,
  output logic [15:0]             entry_rate_o,
  output logic [20:0]             total_rate_o,
  output logic                    last_o
);
  import cirm_pkg::*;

  logic [31:0] window_q;
  logic [1:0]  cmd_q;
  logic [29:0] ident_q;
  logic [63:0] data_q;
  logic [3:0]  len_q;
  logic [31:0] now_q;
  logic [5:0]  limit_q;
  logic [CntW-1:0] used_q;
  logic        win_started_q;
  logic [31:0] win_begin_q;
  logic [TotW-1:0] sum_q;
  logic        match_q;
  logic        have_key_q;
  logic [29:0] key_q;
  logic        cand_ok_q;
  logic [29:0] cand_q;
  logic [IdxW-1:0] cand_idx_q;
  logic [IdxW-1:0] cmp_addr_q;
  logic        out_valid_q;

  entry_t rd_ent, wr_ent;
  logic   we;
  logic [IdxW-1:0] waddr;

  cirm_ram #(.Width(EntryW), .Depth(MaxIds)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wr_ent),
    .re_i(cmd_i.rd_en), .raddr_i(cmd_i.rd_addr), .rdata_o(rd_ent)
  );

  logic [3:0]  len_c;
  logic [63:0] mask_c;
  always_comb begin
    len_c  = (dlc_i > DataMax) ? DataMax : dlc_i;
    mask_c = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < len_c) mask_c[b*8 +: 8] = 8'hFF;
    end
  end

  always_comb begin
    wr_ent = rd_ent;
    we     = 1'b0;
    waddr  = cmp_addr_q;
    if (cmd_i.wr_new) begin
      we           = 1'b1;
      waddr        = used_q[IdxW-1:0];
      wr_ent.ident = ident_q;
      wr_ent.data  = data_q;
      wr_ent.len   = len_q;
      wr_ent.total = 32'd1;
      wr_ent.stamp = now_q;
      wr_ent.tally = 16'd1;
      wr_ent.rate  = '0;
    end else if (cmd_i.wr_rec) begin
      we           = 1'b1;
      wr_ent.data  = data_q;
      wr_ent.len   = len_q;
      wr_ent.total = rd_ent.total + 32'd1;
      wr_ent.stamp = now_q;
      if (rd_ent.tally != TallyMax) wr_ent.tally = rd_ent.tally + 16'd1;
    end else if (cmd_i.wr_latch) begin
      we           = 1'b1;
      wr_ent.rate  = rd_ent.tally;
      wr_ent.tally = '0;
    end
  end

  logic [CntW-1:0] snap_cnt;
  always_comb begin
    if ({1'b0, limit_q} < 7'(used_q)) snap_cnt = CntW'(limit_q);
    else snap_cnt = used_q;
  end

  logic [TotW:0] sum_next;
  assign sum_next = {1'b0, sum_q} + (TotW+1)'(rd_ent.rate);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= WindowRst;
      used_q        <= '0;
      win_started_q <= 1'b0;
      win_begin_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) window_q <= cfg_wdata_i;
      if (cmd_i.wr_new) used_q <= used_q + CntW'(1);
      if (cmd_i.clear) used_q <= '0;
      if (cmd_i.win_set) begin
        win_started_q <= 1'b1;
        win_begin_q   <= now_q;
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= command_i;
      ident_q <= {extended_i, can_id_i};
      data_q  <= payload_i & mask_c;
      len_q   <= len_c;
      now_q   <= time_us_i;
      limit_q <= snapshot_limit_i;
      match_q <= 1'b0;
    end
    cmp_addr_q <= cmd_i.rd_addr;
    if (cmd_i.scan_cmp && !match_q && rd_ent.ident == ident_q) begin
      match_q <= 1'b1;
    end
    if (cmd_i.sum_clr) sum_q <= '0;
    else if (cmd_i.sum_add) sum_q <= sum_next[TotW] ? TotMax : sum_next[TotW-1:0];
    if (cmd_i.capture) have_key_q <= 1'b0;
    if (cmd_i.sel_init) cand_ok_q <= 1'b0;
    if (cmd_i.sel_cmp && (!have_key_q || rd_ent.ident > key_q)
        && (!cand_ok_q || rd_ent.ident < cand_q)) begin
      cand_ok_q  <= 1'b1;
      cand_q     <= rd_ent.ident;
      cand_idx_q <= cmp_addr_q;
    end
    if (cmd_i.sel_take) begin
      have_key_q <= 1'b1;
      key_q      <= cand_q;
    end
    if (cmd_i.out_load) begin
      status_o     <= cmd_i.out_status;
      last_o       <= cmd_i.out_last;
      total_rate_o <= sum_q;
      if (cmd_i.out_entry) begin
        entry_can_id_o       <= rd_ent.ident[28:0];
        entry_extended_o     <= rd_ent.ident[29];
        entry_dlc_o          <= rd_ent.len;
        entry_payload_o      <= rd_ent.data;
        entry_frame_count_o  <= rd_ent.total;
        entry_last_time_us_o <= rd_ent.stamp;
        entry_rate_o         <= rd_ent.rate;
      end else begin
        entry_can_id_o       <= '0;
        entry_extended_o     <= 1'b0;
        entry_dlc_o          <= '0;
        entry_payload_o      <= '0;
        entry_frame_count_o  <= '0;
        entry_last_time_us_o <= '0;
        entry_rate_o         <= '0;
      end
    end
  end

  // match is the registered result of the scan compare
  assign stat_o.command     = cmd_q;
  assign stat_o.used        = used_q;
  assign stat_o.snap_cnt    = snap_cnt;
  assign stat_o.match       = match_q;
  assign stat_o.win_started = win_started_q;
  assign stat_o.win_elapsed = (now_q - win_begin_q) >= window_q;
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;
  assign stat_o.sel_idx     = cand_idx_q;
  assign out_valid_o        = out_valid_q;

  ap_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(MaxIds)) else $error("table count beyond depth");
  ap_no_new_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> used_q < CntW'(MaxIds)) else $error("new entry on full table");
  ap_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_i.wr_new, cmd_i.wr_rec, cmd_i.wr_latch}) <= 1)
    else $error("write conflict");
  ap_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i)) else $error("output overrun");
endmodule
`default_nettype wire

### rtl/core/cirm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cirm_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire cirm_pkg::stat_t stat_i,
  output cirm_pkg::cmd_t       cmd_o
);
  import cirm_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SDisp = 4'd1, SScan = 4'd2, SRecW = 4'd3,
                         SLatR = 4'd4, SLatW = 4'd5, SSumR = 4'd6, SSum = 4'd7,
                         SSelR = 4'd8, SSel = 4'd9, SEmitR = 4'd10, SEmit = 4'd11,
                         SPlain = 4'd12, SRecD = 4'd13;

  logic [3:0]      state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] emit_q, emit_d;
  logic [2:0]      st_q, st_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    emit_d  = emit_q;
    st_d    = st_q;
    cmd_o   = '0;
    in_ready_o = (state_q == SIdle);
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.capture = 1'b1;
        state_d = SDisp;
      end
      SDisp: begin
        idx_d = '0;
        unique case (stat_i.command)
          CmdRecord: state_d = SScan;
          CmdTime: begin
            if (!stat_i.win_started) begin
              cmd_o.win_set = 1'b1; st_d = StWinStart; state_d = SSumR;
            end else if (!stat_i.win_elapsed) begin
              st_d = StWinOpen; state_d = SSumR;
            end else begin
              cmd_o.win_set = 1'b1; st_d = StLatched; state_d = SLatR;
            end
          end
          CmdSnap: begin
            emit_d = '0;
            if (stat_i.snap_cnt == '0) begin
              st_d = StEmpty; state_d = SSumR;
            end else state_d = SSumR;
            if (stat_i.snap_cnt != '0) st_d = StEntry;
          end
          default: begin
            cmd_o.clear = 1'b1; st_d = StCleared; state_d = SSumR;
          end
        endcase
      end
      // read each used entry, compare it in SRecD
      SScan: begin
        if (idx_q < stat_i.used) begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = idx_q[IdxW-1:0];
          state_d = SRecD;
        end else if (stat_i.used == CntW'(MaxIds)) begin
          st_d = StDropped; state_d = SSumR;
        end else begin
          cmd_o.wr_new = 1'b1; st_d = StStored; state_d = SSumR;
        end
      end
      SRecD: begin
        cmd_o.rd_addr = idx_q[IdxW-1:0];
        cmd_o.scan_cmp = 1'b1;
        state_d = SRecW;
      end
      SRecW: begin
        if (stat_i.match) begin
          // re-read held: rd data still valid for write-back
          cmd_o.rd_addr = idx_q[IdxW-1:0];
          cmd_o.wr_rec = 1'b1; st_d = StStored; state_d = SSumR;
        end else begin
          idx_d = idx_q + CntW'(1); state_d = SScan;
        end
      end
      SLatR: begin
        if (idx_q < stat_i.used) begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = idx_q[IdxW-1:0];
          state_d = SLatW;
        end else state_d = SSumR;
      end
      SLatW: begin
        cmd_o.rd_addr = idx_q[IdxW-1:0];
        cmd_o.wr_latch = 1'b1;
        idx_d = idx_q + CntW'(1); state_d = SLatR;
      end
      SSumR: begin
        cmd_o.sum_clr = 1'b1; idx_d = '0;
        if (stat_i.used != '0) begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = '0;
          idx_d = CntW'(1);
          state_d = SSum;
        end else state_d = (st_q == StEntry) ? SSelR : SPlain;
      end
      SSum: begin
        cmd_o.sum_add = 1'b1;
        if (idx_q < stat_i.used) begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = idx_q[IdxW-1:0];
          idx_d = idx_q + CntW'(1);
        end else state_d = (st_q == StEntry) ? SSelR : SPlain;
      end
      SPlain: if (!stat_i.out_busy) begin
        cmd_o.out_load = 1'b1; cmd_o.out_status = st_q; cmd_o.out_last = 1'b1;
        state_d = SIdle;
      end
      // selection pass: smallest ident above the last emitted key
      SSelR: begin
        cmd_o.sel_init = 1'b1;
        cmd_o.rd_en = 1'b1; cmd_o.rd_addr = '0;
        idx_d = CntW'(1); state_d = SSel;
      end
      SSel: begin
        cmd_o.sel_cmp = 1'b1;
        if (idx_q < stat_i.snap_cnt) begin
          cmd_o.rd_en = 1'b1; cmd_o.rd_addr = idx_q[IdxW-1:0];
          idx_d = idx_q + CntW'(1);
        end else state_d = SEmitR;
      end
      SEmitR: begin
        cmd_o.sel_take = 1'b1;
        cmd_o.rd_en = 1'b1; cmd_o.rd_addr = stat_i.sel_idx;
        state_d = SEmit;
      end
      SEmit: if (!stat_i.out_busy) begin
        cmd_o.out_load = 1'b1; cmd_o.out_entry = 1'b1; cmd_o.out_status = StEntry;
        cmd_o.out_last = (emit_q + CntW'(1) == stat_i.snap_cnt);
        emit_d = emit_q + CntW'(1);
        state_d = cmd_o.out_last ? SIdle : SSelR;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      emit_q  <= '0;
      st_q    <= StStored;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      emit_q  <= emit_d;
      st_q    <= st_d;
    end
  end

  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.out_load) else $error("load while idle");
  ap_cap_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == SDisp) else $error("capture lost");
  ap_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && cmd_o.out_last) |=> in_ready_o) else $error("last without idle");
endmodule
`default_nettype wire

### rtl/core/can_id_rate_monitor.sv
// CAN identifier rate monitor.
// Input channel in_valid_i/in_ready_o carries one command item: record a frame,
// time update, sorted snapshot or clear. Output channel out_valid_o/out_ready_i
// delivers result items; last_o marks the final result of an input item.
// The user writes window_us through cfg_we_i/cfg_wdata_i only while the block
// is idle; the block does not enforce this. One item is worked at a time;
// in_ready_o is high only between items. A record scans the entries in use
// for its identifier, then updates the match, adds a new entry or drops the
// frame on a full table; a time update may first latch rates; clear empties
// the table. Each item then sums the rates in a pass for total_rate_o.
// Each pass reads the entry table through its one read port. Snapshot: a sum
// pass, then each of its C results after a selection pass over the first C
// entries; results come from a selection sort over the single RAM read port.
// Reset empties the table, closes the window and sets window_us to 1000000;
// the entry RAM is not cleared, entries are written before they are read.
// A stalled receiver holds the result register; the controller waits before
// loading the next result, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module can_id_rate_monitor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [28:0] can_id_i,
  input  wire logic        extended_i,
  input  wire logic [63:0] payload_i,
  input  wire logic [3:0]  dlc_i,
  input  wire logic [31:0] time_us_i,
  input  wire logic [5:0]  snapshot_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [28:0]      entry_can_id_o,
  output logic             entry_extended_o,
  output logic [3:0]       entry_dlc_o,
  output logic [63:0]      entry_payload_o,
  output logic [31:0]      entry_frame_count_o,
  output logic [31:0]      entry_last_time_us_o,
  output logic [15:0]      entry_rate_o,
  output logic [20:0]      total_rate_o,
  output logic             last_o
);
  import cirm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cirm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .stat_i(stat), .cmd_o(cmd)
  );

  cirm_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .command_i, .can_id_i, .extended_i, .payload_i, .dlc_i, .time_us_i,
    .snapshot_limit_i, .cmd_i(cmd), .stat_o(stat),
    .out_valid_o, .out_ready_i, .status_o, .entry_can_id_o, .entry_extended_o,
    .entry_dlc_o, .entry_payload_o, .entry_frame_count_o, .entry_last_time_us_o,
    .entry_rate_o, .total_rate_o, .last_o
  );
endmodule
`default_nettype wire

### sim/can_id_rate_monitor_tb.sv
`timescale 1ns / 1ps
module can_id_rate_monitor_tb;
  import cirm_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [28:0] can_id;
    logic        extended;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [31:0] frame_count;
    logic [31:0] last_time;
    logic [15:0] rate;
    logic [20:0] total_rate;
    logic        last;
  } monitor_res_t;

  // Shadow of the identifier table plus the queue of results it predicts.
  class rate_table_scoreboard;
    logic [31:0]  window_len;
    int unsigned  n_used;
    logic [29:0]  ident[MaxIds];
    logic [63:0]  data[MaxIds];
    logic [3:0]   len[MaxIds];
    logic [31:0]  total[MaxIds];
    logic [31:0]  stamp[MaxIds];
    logic [15:0]  tally[MaxIds];
    logic [15:0]  rate[MaxIds];
    logic         win_on;
    logic [31:0]  win_begin;
    monitor_res_t pending[$];
    int unsigned  errors;
    int unsigned  n_results;
    int unsigned  n_dropped, n_latched, n_snap_rows;

    function void reset_state();
      window_len = WindowRst;
      n_used = 0;
      win_on = 0;
      win_begin = '0;
      pending.delete();
    endfunction

    function logic [20:0] rate_total();
      int unsigned s;
      s = 0;
      for (int i = 0; i < n_used; i++) s += rate[i];
      return (s > TotMax) ? TotMax : s[20:0];
    endfunction

    function void push_plain(logic [2:0] st);
      monitor_res_t r;
      r = '0;
      r.status = st;
      r.total_rate = rate_total();
      r.last = 1'b1;
      pending.push_back(r);
    endfunction

    function void note_item(logic [1:0] cmd, logic [28:0] id, logic ext,
                            logic [63:0] pl, logic [3:0] dl, logic [31:0] now,
                            logic [5:0] lim);
      logic [29:0] key;
      int unsigned slot, cnt, e, j;
      int unsigned order[MaxIds];
      monitor_res_t r;
      logic [3:0] dc;
      key = {ext, id};
      case (cmd)
        CmdRecord: begin
          slot = n_used;
          for (int i = 0; i < n_used; i++)
            if (ident[i] == key) begin
              slot = i;
              break;
            end
          if (slot >= MaxIds) begin
            n_dropped++;
            push_plain(StDropped);
          end else begin
            if (slot == n_used) begin
              n_used++;
              ident[slot] = key;
              total[slot] = 0;
              tally[slot] = 0;
              rate[slot] = 0;
            end
            dc = (dl > DataMax) ? DataMax : dl;
            len[slot] = dc;
            data[slot] = (dc == DataMax) ? pl : (pl & ((64'd1 << (8 * dc)) - 64'd1));
            total[slot] = total[slot] + 1;
            if (tally[slot] != TallyMax) tally[slot] = tally[slot] + 1;
            stamp[slot] = now;
            push_plain(StStored);
          end
        end
        CmdTime: begin
          if (!win_on) begin
            win_on = 1;
            win_begin = now;
            push_plain(StWinStart);
          end else if (32'(now - win_begin) < window_len) begin
            push_plain(StWinOpen);
          end else begin
            for (int i = 0; i < n_used; i++) begin
              rate[i] = tally[i];
              tally[i] = 0;
            end
            win_begin = now;
            n_latched++;
            push_plain(StLatched);
          end
        end
        CmdSnap: begin
          cnt = (n_used < lim) ? n_used : lim;
          if (cnt > MaxIds) cnt = MaxIds;
          if (cnt == 0) push_plain(StEmpty);
          else begin
            for (int i = 0; i < cnt; i++) begin
              j = i;
              while (j > 0 && ident[order[j-1]] > ident[i]) begin
                order[j] = order[j-1];
                j--;
              end
              order[j] = i;
            end
            for (int i = 0; i < cnt; i++) begin
              e = order[i];
              r.status = StEntry;
              {r.extended, r.can_id} = ident[e];
              r.dlc = len[e];
              r.payload = data[e];
              r.frame_count = total[e];
              r.last_time = stamp[e];
              r.rate = rate[e];
              r.total_rate = rate_total();
              r.last = (i == cnt - 1);
              pending.push_back(r);
              n_snap_rows++;
            end
          end
        end
        default: begin
          n_used = 0;
          push_plain(StCleared);
        end
      endcase
    endfunction

    function void check_result(monitor_res_t got);
      monitor_res_t exp_r;
      n_results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status != exp_r.status) fail_field("status", exp_r.status, got.status);
      if (got.can_id != exp_r.can_id) fail_field("can_id", exp_r.can_id, got.can_id);
      if (got.extended != exp_r.extended)
        fail_field("extended", exp_r.extended, got.extended);
      if (got.dlc != exp_r.dlc) fail_field("dlc", exp_r.dlc, got.dlc);
      if (got.payload != exp_r.payload) fail_field("payload", exp_r.payload, got.payload);
      if (got.frame_count != exp_r.frame_count)
        fail_field("frame_count", exp_r.frame_count, got.frame_count);
      if (got.last_time != exp_r.last_time)
        fail_field("last_time", exp_r.last_time, got.last_time);
      if (got.rate != exp_r.rate) fail_field("rate", exp_r.rate, got.rate);
      if (got.total_rate != exp_r.total_rate)
        fail_field("total_rate", exp_r.total_rate, got.total_rate);
      if (got.last != exp_r.last) fail_field("last", exp_r.last, got.last);
    endfunction

    function void fail_field(string name, logic [63:0] e, logic [63:0] a);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      errors++;
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  command_i;
  logic [28:0] can_id_i;
  logic        extended_i;
  logic [63:0] payload_i;
  logic [3:0]  dlc_i;
  logic [31:0] time_us_i;
  logic [5:0]  snapshot_limit_i;
  logic        out_valid_o, out_ready_i;
  monitor_res_t res;
  logic        rx_on;

  can_id_rate_monitor dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .can_id_i, .extended_i,
    .payload_i, .dlc_i, .time_us_i, .snapshot_limit_i,
    .out_valid_o, .out_ready_i,
    .status_o(res.status), .entry_can_id_o(res.can_id),
    .entry_extended_o(res.extended), .entry_dlc_o(res.dlc),
    .entry_payload_o(res.payload), .entry_frame_count_o(res.frame_count),
    .entry_last_time_us_o(res.last_time), .entry_rate_o(res.rate),
    .total_rate_o(res.total_rate), .last_o(res.last)
  );

  rate_table_scoreboard sb;
  logic [31:0] clock_us;
  logic [28:0] id_pool[8];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stall per result, sampled at the edge.
  initial begin
    int unsigned gap;
    out_ready_i = 0;
    wait (rx_on === 1'b1);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(res);
    end
  end

  // valid stays high after acceptance until the next item or a pause drops it
  task automatic send(logic [1:0] cmd, logic [28:0] id, logic ext, logic [63:0] pl,
                      logic [3:0] dl, logic [31:0] now, logic [5:0] lim);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    can_id_i <= id;
    extended_i <= ext;
    payload_i <= pl;
    dlc_i <= dl;
    time_us_i <= now;
    snapshot_limit_i <= lim;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(cmd, id, ext, pl, dl, now, lim);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_window(logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.window_len = v;
  endtask

  task automatic rand_item(int unsigned wide);
    int unsigned sel;
    logic [28:0] id;
    sel = $urandom_range(0, 99);
    id = (wide != 0) ? 29'($urandom) : id_pool[$urandom_range(0, 7)];
    clock_us = clock_us + $urandom_range(0, 400);
    if (sel < 65)
      send(CmdRecord, id, 1'($urandom_range(0, 1)), {$urandom, $urandom},
           4'($urandom_range(0, 15)), clock_us, 6'($urandom));
    else if (sel < 85)
      send(CmdTime, 29'($urandom), 1'($urandom_range(0, 1)), {$urandom, $urandom},
           4'($urandom), ($urandom_range(0, 9) == 0) ? $urandom : clock_us,
           6'($urandom));
    else if (sel < 97)
      send(CmdSnap, 29'($urandom), 1'($urandom_range(0, 1)), {$urandom, $urandom},
           4'($urandom), $urandom, 6'($urandom_range(0, 63)));
    else
      send(CmdClear, 29'($urandom), 1'($urandom_range(0, 1)), {$urandom, $urandom},
           4'($urandom), $urandom, 6'($urandom));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rx_on = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_wdata_i = '0;
    in_valid_i = 0;
    command_i = CmdRecord;
    can_id_i = '0;
    extended_i = 0;
    payload_i = '0;
    dlc_i = '0;
    time_us_i = '0;
    snapshot_limit_i = '0;
    clock_us = 32'd100;
    for (int i = 0; i < 8; i++)
      id_pool[i] = (i < 4) ? 29'($urandom_range(0, 2047)) : 29'($urandom);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    rx_on = 1;
    @(posedge clk_i);

    // Directed: empty snapshot, extremes, clamp, window start/open/latch.
    send(CmdSnap, 0, 0, 0, 0, 0, 6'd32);
    send(CmdRecord, 29'h1FFFFFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFFFFFF, 6'd63);
    send(CmdRecord, 29'h1FFFFFFF, 0, 64'h0123_4567_89AB_CDEF, 4'd3, 32'd0, 0);
    send(CmdRecord, 29'd0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'd5, 0);
    send(CmdRecord, 29'd0, 1, 64'hA5A5_5A5A_0F0F_F0F0, 4'd8, 32'd6, 0);
    send(CmdRecord, 29'h1FFFFFFF, 1, 64'h1122_3344_5566_7788, 4'd5, 32'd7, 0);
    send(CmdSnap, 0, 0, 0, 0, 0, 6'd0);
    send(CmdSnap, 0, 0, 0, 0, 0, 6'd63);
    send(CmdSnap, 0, 0, 0, 0, 0, 6'd2);
    send(CmdTime, 0, 0, 0, 0, 32'hFFFF_FF00, 0);
    send(CmdTime, 0, 0, 0, 0, 32'd10, 0);
    send(CmdTime, 0, 0, 0, 0, 32'd1000000, 0);
    send(CmdSnap, 0, 0, 0, 0, 0, 6'd32);
    drain();
    write_window(32'd0);
    send(CmdTime, 0, 0, 0, 0, 32'd1000000, 0);
    send(CmdClear, 0, 0, 0, 0, 0, 0);
    send(CmdSnap, 0, 0, 0, 0, 0, 6'd5);
    // Fill the table past capacity to hit the drop case.
    for (int i = 0; i < MaxIds + 2; i++)
      send(CmdRecord, 29'(i * 3), i[0], {$urandom, $urandom}, 4'd8, 32'(i), 0);
    send(CmdSnap, 0, 0, 0, 0, 0, 6'd63);
    drain();
    write_window(32'hFFFF_FFFF);
    send(CmdTime, 0, 0, 0, 0, 32'd5, 0);
    send(CmdClear, 0, 0, 0, 0, 0, 0);
    drain();
    write_window(32'd1);
    for (int i = 0; i < 30; i++) rand_item(i % 7 == 0);
    drain();
    write_window(32'd700);
    for (int i = 0; i < 30; i++) rand_item(i % 9 == 0);
    send(CmdSnap, 0, 0, 0, 0, 0, 6'd32);
    drain();

    $display("Covered %0d results: %0d drops, %0d rate latches, %0d snapshot rows.",
             sb.n_results, sb.n_dropped, sb.n_latched, sb.n_snap_rows);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
